FILE: hw/rtl/csp_pkg.sv
// Shared types, constants and helper functions for the colour spec parser.
package csp_pkg;

  localparam int MaxChars = 16;
  localparam int CntW = $clog2(MaxChars + 1);
  localparam int IdxW = $clog2(MaxChars);
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    FORM_HEX6 = 2'd0,
    FORM_HEX3 = 2'd1,
    FORM_NUM  = 2'd2,
    FORM_NAME = 2'd3
  } form_t;

  // One parse job handed from the front part to the back part.
  typedef struct packed {
    logic [CntW-1:0] len;
    logic            ovf;
  } job_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return (l >= 8'h30 && l <= 8'h39) || (l >= 8'h61 && l <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    logic [7:0] d;
    l = to_lower(c);
    d = (l <= 8'h39) ? (l - 8'h30) : (l - 8'h57);
    return d[3:0];
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h00;
      3'd1: r = 8'h5F;
      3'd2: r = 8'h87;
      3'd3: r = 8'hAF;
      3'd4: r = 8'hD7;
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] palette(input logic [7:0] n);
    logic [7:0] r, g, b, m, v;
    logic [2:0] q36, q6, r6;
    logic [7:0] t;
    r = 8'd0; g = 8'd0; b = 8'd0;
    if (n < 8'd16) begin
      r = n[0] ? 8'h80 : 8'h00;
      g = n[1] ? 8'h80 : 8'h00;
      b = n[2] ? 8'h80 : 8'h00;
      if (n[3]) begin
        if (n[0]) r = r + 8'h7f;
        if (n[1]) g = g + 8'h7f;
        if (n[2]) b = b + 8'h7f;
        if (n == 8'd8) begin
          r = 8'h80; g = 8'h80; b = 8'h80;
        end
      end
      if (n == 8'd7) begin
        r = r + 8'h40; g = g + 8'h40; b = b + 8'h40;
      end
    end else if (n < 8'd232) begin
      m = n - 8'd16;
      q36 = 3'((16'(m) * 16'd57) >> 11);
      t = m - 8'(q36) * 8'd36;
      q6 = 3'((16'(t) * 16'd43) >> 8);
      r6 = 3'(t - 8'(q6) * 8'd6);
      r = cube_level(q36); g = cube_level(q6); b = cube_level(r6);
    end else begin
      v = 8'((n - 8'd232) * 8'd10 + 8'd8);
      r = v; g = v; b = v;
    end
    return {r, g, b};
  endfunction

endpackage

FILE: hw/rtl/csp_front.sv
// Front part: collects characters into the buffer and queues a parse job per spec.
module csp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  input  logic                 in_last,
  output logic                 wr_en,
  output logic [csp_pkg::IdxW-1:0] wr_idx,
  output logic [7:0]           wr_data,
  output logic                 job_valid,
  output csp_pkg::job_t        job,
  input  logic                 job_ready
);
  import csp_pkg::*;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic            acc;

  // The buffer is shared with the back part, so a new spec waits until the job is taken.
  assign in_ready  = !job_valid || job_ready;
  assign acc       = in_valid && in_ready;
  assign wr_en     = acc && (cnt_r < CntW'(MaxChars));
  assign wr_idx    = cnt_r[IdxW-1:0];
  assign wr_data   = in_ch;

  logic jv_r;
  job_t job_r;
  assign job_valid = jv_r;
  assign job       = job_r;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (acc) begin
      if (cnt_r < CntW'(MaxChars)) cnt_nxt = cnt_r + 1'b1;
      else ovf_nxt = 1'b1;
      if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      jv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      jv_r  <= (acc && in_last) || (jv_r && !job_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_last) begin
      job_r.len <= (cnt_r < CntW'(MaxChars)) ? cnt_r + 1'b1 : cnt_r;
      job_r.ovf <= ovf_r || !(cnt_r < CntW'(MaxChars));
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxChars)) else $error("count above buffer size");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (jv_r && !job_ready) |-> !in_ready) else $error("accepted while job pending");
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last) |=> (cnt_r == '0 && !ovf_r)) else $error("count not cleared");
`endif
endmodule

FILE: hw/rtl/csp_back.sv
// Back part: owns the character buffer and parses a queued spec into a colour.
module csp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [csp_pkg::IdxW-1:0] wr_idx,
  input  logic [7:0]           wr_data,
  input  logic                 job_valid,
  input  csp_pkg::job_t        job,
  output logic                 job_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_valid_res,
  output logic [1:0]           out_form,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue
);
  import csp_pkg::*;

  logic [7:0] mem_r [MaxChars];
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_idx] <= wr_data;
  end

  // A bright name can reach byte 14 of the buffer, so every byte is lower-cased.
  logic [7:0] c [MaxChars];
  logic [CntW-1:0] len;
  always_comb begin
    for (int i = 0; i < MaxChars; i++) c[i] = to_lower(mem_r[i]);
    len = job.len;
  end

  logic hex6_ok, hex3_ok, col_ok, col_pre;
  logic [9:0] num;
  logic dig_ok;
  logic bright;
  logic [CntW-1:0] noff;
  logic [3:0] base;
  logic name_ok;
  logic [7:0] pal_n;
  logic [23:0] rgb;
  logic [1:0] frm;
  logic ok;

  function automatic logic nm(input logic [7:0] cc [MaxChars], input int off,
                              input logic [71:0] w, input int wl);
    logic r;
    r = 1'b1;
    for (int i = 0; i < 9; i++)
      if (i < wl && (off + i) < MaxChars && cc[off + i] != w[71 - 8*i -: 8]) r = 1'b0;
    return r;
  endfunction

  always_comb begin
    hex6_ok = (len == CntW'(7)) && (mem_r[0] == 8'h23);
    for (int i = 1; i < 7; i++) if (!is_hex(mem_r[i])) hex6_ok = 1'b0;
    hex3_ok = (len == CntW'(4)) && (mem_r[0] == 8'h23);
    for (int i = 1; i < 4; i++) if (!is_hex(mem_r[i])) hex3_ok = 1'b0;
    col_pre = nm(c, 0, {"color", 32'h0}, 5);
    dig_ok = 1'b1;
    num = '0;
    for (int i = 5; i < 8; i++) begin
      if (CntW'(i) < len) begin
        if (!(mem_r[i] >= 8'h30 && mem_r[i] <= 8'h39)) dig_ok = 1'b0;
        num = 10'(num * 10'd10 + 10'(mem_r[i] - 8'h30));
      end
    end
    col_ok = (len >= CntW'(6)) && (len <= CntW'(8)) && col_pre && dig_ok &&
             (num <= 10'd255);
    bright = (len >= CntW'(6)) && nm(c, 0, {"bright", 24'h0}, 6);
    noff = bright ? CntW'(6) : '0;
    name_ok = 1'b1;
    base = '0;
    if      (len == noff + CntW'(5) && nm(c, int'(noff), {"black", 32'h0}, 5))   base = 4'd0;
    else if (len == noff + CntW'(3) && nm(c, int'(noff), {"red", 48'h0}, 3))     base = 4'd1;
    else if (len == noff + CntW'(5) && nm(c, int'(noff), {"green", 32'h0}, 5))   base = 4'd2;
    else if (len == noff + CntW'(6) && nm(c, int'(noff), {"yellow", 24'h0}, 6))  base = 4'd3;
    else if (len == noff + CntW'(5) && nm(c, int'(noff), {"brown", 32'h0}, 5))   base = 4'd3;
    else if (len == noff + CntW'(4) && nm(c, int'(noff), {"blue", 40'h0}, 4))    base = 4'd4;
    else if (len == noff + CntW'(7) && nm(c, int'(noff), {"magenta", 16'h0}, 7)) base = 4'd5;
    else if (len == noff + CntW'(4) && nm(c, int'(noff), {"cyan", 40'h0}, 4))    base = 4'd6;
    else if (len == noff + CntW'(5) && nm(c, int'(noff), {"white", 32'h0}, 5))   base = 4'd7;
    else if (len == noff + CntW'(9) && nm(c, int'(noff), "lightgray", 9))       base = 4'd7;
    else if (len == noff + CntW'(4) && nm(c, int'(noff), {"grey", 40'h0}, 4))    base = 4'd7;
    else name_ok = 1'b0;
    ok = 1'b1; frm = FORM_NAME; rgb = '0; pal_n = {4'd0, base};
    if (hex6_ok) begin
      frm = FORM_HEX6;
      rgb = {hex_val(mem_r[1]), hex_val(mem_r[2]), hex_val(mem_r[3]),
             hex_val(mem_r[4]), hex_val(mem_r[5]), hex_val(mem_r[6])};
    end else if (hex3_ok) begin
      frm = FORM_HEX3;
      rgb = {{2{hex_val(mem_r[1])}}, {2{hex_val(mem_r[2])}}, {2{hex_val(mem_r[3])}}};
    end else if (col_ok) begin
      frm = FORM_NUM; pal_n = num[7:0];
    end else if (name_ok) begin
      frm = FORM_NAME; pal_n = {4'd0, base} + (bright ? 8'd8 : 8'd0);
    end else ok = 1'b0;
    if (job.ovf || len == '0) ok = 1'b0;
  end

  // Stage register between the decode and the palette lookup.
  logic       s_v_r, s_ok_r, s_pal_r;
  logic [1:0] s_frm_r;
  logic [23:0] s_rgb_r;
  logic [7:0] s_n_r;
  logic       s_ready;
  assign job_ready = job_valid && (!s_v_r || s_ready);
  assign s_ready = !out_valid || out_ready;

  logic ov_r;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      s_v_r <= job_ready || (s_v_r && !s_ready);
      ov_r  <= (s_v_r && s_ready) || (ov_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      s_ok_r  <= ok;
      s_frm_r <= frm;
      s_rgb_r <= rgb;
      s_n_r   <= pal_n;
      s_pal_r <= ok && (frm == FORM_NUM || frm == FORM_NAME);
    end
    if (s_v_r && s_ready) begin
      out_valid_res <= s_ok_r;
      out_form      <= s_ok_r ? s_frm_r : 2'd0;
      {out_red, out_green, out_blue} <= !s_ok_r ? 24'd0 :
                                        (s_pal_r ? palette(s_n_r) : s_rgb_r);
    end
  end

`ifndef SYNTHESIS
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_form == 2'd0 && out_red == 8'd0))
    else $error("invalid result not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s_v_r && !s_ready) |=> s_v_r) else $error("stage dropped");
  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_ready |-> job_valid) else $error("job taken without valid");
`endif
endmodule

FILE: hw/rtl/colour_spec_parser_top.sv
// Top level of the colour spec parser.
// Usage: send a spec one character per transaction on in_ch with in_last set
// on its final character. Each spec yields exactly one result transaction on
// the out_ channel: out_valid_res, out_form and the out_red/green/blue values,
// all zero when the spec does not parse. Characters other than the last give
// no result.
// Result path: with the output free, a result passes the front job register,
// the back stage register and the output register after the last character.
// Throughput: one character per cycle, also across specs, as long as the back
// part takes each job in the cycle after its last character; the back part
// decodes straight from the shared character buffer.
// Reset clears the character count, the overflow flag and all valid flags;
// buffer contents are not cleared. When the receiver stalls, the result is
// held, one more job waits in the stage and a third spec is collected in the
// buffer; once its last character is in, in_ready drops until the stage moves.
module colour_spec_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_valid_res,
  output logic [1:0] out_form,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);
  import csp_pkg::*;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [7:0]      wr_data;
  logic            job_valid, job_ready;
  job_t            job;

  csp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_ch, .in_last,
    .wr_en, .wr_idx, .wr_data, .job_valid, .job, .job_ready
  );

  csp_back u_back (
    .clk, .rst_n, .wr_en, .wr_idx, .wr_data, .job_valid, .job, .job_ready,
    .out_valid, .out_ready, .out_valid_res, .out_form, .out_red, .out_green,
    .out_blue
  );
endmodule

FILE: tb/tb_colour_spec_parser_top.sv
// Self-checking testbench for the colour spec parser: directed and random specs.
`timescale 1ns / 100ps

module tb_colour_spec_parser_top;
  import csp_pkg::*;

  typedef struct {
    logic       ok;
    logic [1:0] form;
    logic [7:0] r, g, b;
  } colour_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_ch = 8'd0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_valid_res;
  logic [1:0] out_form;
  logic [7:0] out_red, out_green, out_blue;

  colour_res_t expected_colours[$];
  logic [7:0] spec_buf[$];
  int errors = 0;
  int specs_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  longint cycle_count = 0;

  colour_spec_parser_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] lc(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int hexdig(input logic [7:0] c);
    logic [7:0] l;
    l = lc(c);
    if (l >= "0" && l <= "9") return l - "0";
    if (l >= "a" && l <= "f") return l - "a" + 10;
    return -1;
  endfunction

  function automatic logic [23:0] xterm_rgb(input int n);
    int r, g, b, m, v;
    int lv[6] = '{0, 'h5F, 'h87, 'hAF, 'hD7, 'hFF};
    if (n < 16) begin
      r = n[0] ? 'h80 : 0;
      g = n[1] ? 'h80 : 0;
      b = n[2] ? 'h80 : 0;
      if (n[3]) begin
        if (n[0]) r += 'h7f;
        if (n[1]) g += 'h7f;
        if (n[2]) b += 'h7f;
        if (n == 8) begin
          r = 'h80; g = 'h80; b = 'h80;
        end
      end
      if (n == 7) begin
        r += 'h40; g += 'h40; b += 'h40;
      end
    end else if (n < 232) begin
      m = n - 16;
      r = lv[(m / 36) % 6]; g = lv[(m / 6) % 6]; b = lv[m % 6];
    end else begin
      v = ((n - 232) * 10 + 8) & 'hFF;
      r = v; g = v; b = v;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic bit word_at(input logic [7:0] s[$], input int off, input string w);
    if (off + w.len() > s.size()) return 0;
    foreach (w[i]) if (lc(s[off + i]) != w[i]) return 0;
    return 1;
  endfunction

  function automatic colour_res_t parse_colour(input logic [7:0] s[$]);
    colour_res_t res;
    int len, d, num, off;
    bit ok;
    logic [23:0] rgb;
    string names[11] = '{"black", "red", "green", "yellow", "brown", "blue",
                         "magenta", "cyan", "white", "lightgray", "grey"};
    int idx[11] = '{0, 1, 2, 3, 3, 4, 5, 6, 7, 7, 7};
    res = '{1'b0, 2'd0, 8'd0, 8'd0, 8'd0};
    len = s.size();
    if (len == 0 || len > MaxChars) return res;
    if (len == 7 && s[0] == "#") begin
      ok = 1;
      for (int i = 1; i < 7; i++) if (hexdig(s[i]) < 0) ok = 0;
      if (ok) begin
        res.ok = 1; res.form = FORM_HEX6;
        res.r = 8'((hexdig(s[1]) << 4) | hexdig(s[2]));
        res.g = 8'((hexdig(s[3]) << 4) | hexdig(s[4]));
        res.b = 8'((hexdig(s[5]) << 4) | hexdig(s[6]));
        return res;
      end
    end
    if (len == 4 && s[0] == "#") begin
      ok = 1;
      for (int i = 1; i < 4; i++) if (hexdig(s[i]) < 0) ok = 0;
      if (ok) begin
        res.ok = 1; res.form = FORM_HEX3;
        res.r = 8'(hexdig(s[1]) * 17);
        res.g = 8'(hexdig(s[2]) * 17);
        res.b = 8'(hexdig(s[3]) * 17);
        return res;
      end
    end
    if (len >= 6 && len <= 8 && word_at(s, 0, "color")) begin
      ok = 1; num = 0;
      for (int i = 5; i < len; i++) begin
        if (s[i] < "0" || s[i] > "9") ok = 0;
        else num = num * 10 + (s[i] - "0");
      end
      if (ok && num <= 255) begin
        rgb = xterm_rgb(num);
        res.ok = 1; res.form = FORM_NUM; {res.r, res.g, res.b} = rgb;
        return res;
      end
    end
    off = word_at(s, 0, "bright") ? 6 : 0;
    for (int i = 0; i < 11; i++) begin
      if (len - off == names[i].len() && word_at(s, off, names[i])) begin
        rgb = xterm_rgb(idx[i] + (off ? 8 : 0));
        res.ok = 1; res.form = FORM_NAME; {res.r, res.g, res.b} = rgb;
        return res;
      end
    end
    return res;
  endfunction

  // Valid stays high after the transaction; the next idle cycle or drain drops it.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_spec(input string txt, input int pad = 0);
    logic [7:0] s[$];
    int n;
    foreach (txt[i]) s.push_back(txt[i]);
    for (int i = 0; i < pad; i++) s.push_back(8'($urandom_range(255)));
    n = s.size();
    if (n == 0) s.push_back(8'($urandom_range(255)));
    n = s.size();
    if (n > MaxChars) expected_colours.push_back(colour_res_t'{1'b0, 2'd0, 8'd0, 8'd0, 8'd0});
    else expected_colours.push_back(parse_colour(s));
    for (int i = 0; i < n; i++) send_char(s[i], i == n - 1);
    specs_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || hold_off > 0 || $urandom_range(99) < recv_idle_pct) out_ready <= 1'b0;
    else out_ready <= 1'b1;
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk) begin
    colour_res_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_colours.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        e = expected_colours.pop_front();
        if (e.ok !== out_valid_res || e.form !== out_form || e.r !== out_red ||
            e.g !== out_green || e.b !== out_blue) begin
          $display("%0t: mismatch exp %b/%0d/%h%h%h got %b/%0d/%h%h%h", $time,
                   e.ok, e.form, e.r, e.g, e.b, out_valid_res, out_form,
                   out_red, out_green, out_blue);
          errors++;
        end
      end
    end
  end

  function automatic string hexstr(input int n);
    string h = "0123456789abcdefABCDEF", s = "";
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) s = {s, string'(8'($urandom_range(255)))};
      else s = {s, string'(h[$urandom_range(21)])};
    end
    return s;
  endfunction

  function automatic string mixcase(input string s);
    foreach (s[i]) if ($urandom_range(1) && s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 32;
    return s;
  endfunction

  task automatic test_directed;
    send_spec("#000000"); send_spec("#FFffFF"); send_spec("#a1B2c3");
    send_spec("#fff"); send_spec("#0aF"); send_spec("# 12345"); send_spec("#+12");
    send_spec("color0"); send_spec("COLOR255"); send_spec("color256");
    send_spec("color007"); send_spec("color232"); send_spec("color8");
    send_spec("bright"); send_spec("brightred"); send_spec("BrightGrey");
    send_spec("brightlightgray"); send_spec("brightmagenta"); send_spec("brightblackx");
    send_spec("brightblaxx"); send_spec("brightwhite"); send_spec("brightcyan");
    send_spec("lightgray"); send_spec("brown"); send_spec("yellow");
    send_spec("#12345678901234567"); send_spec("abcdefghijklmnop");
    send_spec("red", 1); send_spec("", 1);
    send_spec({"co", 8'h00, "lor1"}); send_spec("colorx");
  endtask

  task automatic random_spec;
    string names[11] = '{"black", "red", "green", "yellow", "brown", "blue",
                         "magenta", "cyan", "white", "lightgray", "grey"};
    case ($urandom_range(7))
      0: send_spec({"#", hexstr(6)});
      1: send_spec({"#", hexstr(3)});
      2: send_spec(mixcase($sformatf("color%0d", $urandom_range(300))));
      3: send_spec(mixcase({$urandom_range(1) ? "bright" : "", names[$urandom_range(10)]}));
      4: send_spec(mixcase("color"), $urandom_range(3));
      5: send_spec("", $urandom_range(1, 20));
      6: send_spec(mixcase($sformatf("color%03d", $urandom_range(255))));
      default: send_spec({"#", hexstr($urandom_range(1, 8))});
    endcase
  endtask

  task automatic test_random(input int n_specs, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_specs; i++) random_spec();
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 300;
    for (int i = 0; i < 20; i++) random_spec();
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_random(80, 6, 83);
    test_random(80, 83, 6);
    test_random(80, 0, 0);
    test_backpressure();
    test_random(60, 20, 20);
    drain();
    $display("Sent %0d specs (hex, colorN, names, overflow, noise); %0d results checked.",
             specs_sent, results_seen);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: colour_spec_parser_top.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_front.sv
hw/rtl/csp_back.sv
hw/rtl/colour_spec_parser_top.sv
tb/tb_colour_spec_parser_top.sv
